[hw/rtl/pcrc_pkg.sv]
// Shared constants for the packet CRC-32 check core.
`timescale 1ns / 1ps

package pcrc_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 2048;

    // Byte position saturates at twice the packet limit minus one.
    localparam int unsigned POS_W   = $clog2(2 * MAX_PACKET_BYTES);
    localparam logic [POS_W-1:0] POS_TOP = POS_W'(2 * MAX_PACKET_BYTES - 1);

    localparam int unsigned OFFSET_W = 11;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(8);

    // Window compare width: holds the position and offset + 4.
    localparam int unsigned CMP_W = (POS_W > OFFSET_W + 1) ? POS_W : OFFSET_W + 1;

    localparam int unsigned CRC_W = 32;
    localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;

endpackage

[hw/rtl/pcrc_fold.sv]
// Reflected CRC-32 update over one byte, LSB first.
`timescale 1ns / 1ps

module pcrc_fold
(
    input  logic [pcrc_pkg::CRC_W-1:0] crc_in,
    input  logic [7:0]                 byte_in,
    output logic [pcrc_pkg::CRC_W-1:0] crc_out
);

    always_comb
    begin
        logic [pcrc_pkg::CRC_W-1:0] r;
        r = crc_in ^ {{(pcrc_pkg::CRC_W-8){1'b0}}, byte_in};
        for (int k = 0; k < 8; k++)
        begin
            if (r[0])
            begin
                r = (r >> 1) ^ pcrc_pkg::CRC_POLY;
            end
            else
            begin
                r = r >> 1;
            end
        end
        crc_out = r;
    end

endmodule

[hw/rtl/packet_crc32_check_core.sv]
// Top level: streaming CRC-32 over packet beats with stored-checksum compare.
`timescale 1ns / 1ps
// Result: a last beat's CRC and match flag are registered into the output register when the beat is accepted.
// Throughput: one input beat per cycle while in_stall is low; the byte-wide CRC fold is the combinational path.
// in_stall rises only while a result is held in the output register and out_stall is high.
// Reset (rst_n low, asynchronous): packet-start state, checksum_offset = 8, output empty.

module packet_crc32_check_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: checksum_offset
    input  logic                          cfg_we,
    input  logic [pcrc_pkg::OFFSET_W-1:0] cfg_wdata,
    // input beats
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    // result beats
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pcrc_pkg::CRC_W-1:0]    crc_value,
    output logic                          checksum_match
);

    logic [pcrc_pkg::OFFSET_W-1:0] offset_reg;

    // Per-packet running state.
    logic [pcrc_pkg::CRC_W-1:0]    crc_reg,    crc_next;
    logic [pcrc_pkg::POS_W-1:0]    pos_reg,    pos_next;
    logic [pcrc_pkg::CRC_W-1:0]    stored_reg, stored_next;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    logic [pcrc_pkg::CRC_W-1:0]    crc_value_reg, crc_value_next;
    logic                          match_reg,     match_next;

    logic                          accept;
    logic                          in_window;
    logic [pcrc_pkg::CMP_W-1:0]    pos_ext;
    logic [pcrc_pkg::CMP_W-1:0]    off_ext;
    logic [1:0]                    pos_rel;
    logic [7:0]                    feed;
    logic [pcrc_pkg::CRC_W-1:0]    crc_fold;
    logic [pcrc_pkg::CRC_W-1:0]    crc_final;

    // Output slot frees up when empty or taken this cycle.
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // Checksum window: offset <= pos < offset + 4.
    assign pos_ext   = pcrc_pkg::CMP_W'(pos_reg);
    assign off_ext   = pcrc_pkg::CMP_W'(offset_reg);
    assign pos_rel   = pos_reg[1:0] - offset_reg[1:0];
    assign in_window = (pos_ext >= off_ext) &&
                       (pos_ext < off_ext + pcrc_pkg::CMP_W'(4));

    // Checksum bytes fold in as zero.
    assign feed = in_window ? 8'h00 : data_byte;

    pcrc_fold u_fold
    (
        .crc_in  (crc_reg),
        .byte_in (feed),
        .crc_out (crc_fold)
    );

    assign crc_final = ~crc_fold;

    always_comb
    begin
        crc_next       = crc_reg;
        pos_next       = pos_reg;
        stored_next    = stored_reg;
        out_valid_next = out_valid_reg & out_stall;
        crc_value_next = crc_value_reg;
        match_next     = match_reg;

        if (accept)
        begin
            // Little-endian capture of the stored checksum.
            if (in_window)
            begin
                case (pos_rel)
                    2'd0:    stored_next[7:0]   = data_byte;
                    2'd1:    stored_next[15:8]  = data_byte;
                    2'd2:    stored_next[23:16] = data_byte;
                    default: stored_next[31:24] = data_byte;
                endcase
            end

            if (last_byte)
            begin
                out_valid_next = 1'b1;
                crc_value_next = crc_final;
                match_next     = (crc_final == stored_next);
                // back to packet start
                crc_next       = pcrc_pkg::CRC_PRESET;
                pos_next       = '0;
                stored_next    = '0;
            end
            else
            begin
                crc_next = crc_fold;
                if (pos_reg != pcrc_pkg::POS_TOP)
                begin
                    pos_next = pos_reg + pcrc_pkg::POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= pcrc_pkg::OFFSET_RESET;
            crc_reg       <= pcrc_pkg::CRC_PRESET;
            pos_reg       <= '0;
            stored_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                offset_reg <= cfg_wdata;
            end
            crc_reg       <= crc_next;
            pos_reg       <= pos_next;
            stored_reg    <= stored_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge clk)
    begin
        crc_value_reg <= crc_value_next;
        match_reg     <= match_next;
    end

    assign out_valid      = out_valid_reg;
    assign crc_value      = crc_value_reg;
    assign checksum_match = match_reg;

endmodule

[hw/rtl/pcrc_check.sv]
// Port-level assertions for the packet CRC-32 check core, with bind.
`timescale 1ns / 1ps

module pcrc_check
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          last_byte,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [pcrc_pkg::CRC_W-1:0]    crc_value,
    input logic                          checksum_match
);

    // Held result beat stays up.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // Held result payload stays put.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(crc_value) && $stable(checksum_match))
        else $error("result payload changed while stalled");

    // A last beat produces a result on the next cycle.
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_byte |=> out_valid)
        else $error("last beat gave no result");

    // A non-last beat never invents a result.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !last_byte && !(out_valid && out_stall) |=> !out_valid)
        else $error("result without last beat");

    // Input only backs up behind a held result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free output");

endmodule

bind packet_crc32_check_core pcrc_check u_pcrc_check (.*);

[test/packet_crc32_check_core_test.sv]
// Self-checking testbench for the packet CRC-32 check core.
`timescale 1ns / 1ps

module packet_crc32_check_core_test;

    localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int unsigned RANDOM_BEATS = 800;   // random part, in input beats
    localparam int unsigned PHASE_BEATS  = 220;   // beats per offset setting, at least

    typedef enum int unsigned
    {
        PKT_GOOD,      // checksum field holds the packet's own CRC
        PKT_CORRUPT,   // good packet with one bit flipped somewhere
        PKT_RANDOM     // raw bytes, often shorter than the checksum field
    } pkt_kind_t;

    typedef struct packed
    {
        logic [pcrc_pkg::CRC_W-1:0] crc;
        logic                       match;
    } crc_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [pcrc_pkg::OFFSET_W-1:0] cfg_wdata;
    logic                          in_valid;
    logic                          in_stall;
    logic [7:0]                    data_byte;
    logic                          last_byte;
    logic                          out_valid;
    logic                          out_stall;
    logic [pcrc_pkg::CRC_W-1:0]    crc_value;
    logic                          checksum_match;

    // Predictor copy of the block: configuration plus per-packet state.
    logic [pcrc_pkg::OFFSET_W-1:0] sum_offset   = pcrc_pkg::OFFSET_RESET;
    logic [pcrc_pkg::CRC_W-1:0]    crc_acc      = pcrc_pkg::CRC_PRESET;
    logic [pcrc_pkg::POS_W-1:0]    byte_pos     = '0;
    logic [pcrc_pkg::CRC_W-1:0]    captured_sum = '0;
    crc_result_t                   pending_crc_q[$];

    logic [7:0]          pkt_buf[$];      // packet under construction
    int unsigned         mismatch_count = 0;
    int unsigned         gap_pct   = 0;   // chance of an idle gap before a beat
    int unsigned         stall_pct = 0;   // chance of a receiver stall stretch
    bit                  hold_req    = 1'b0;
    bit                  hold_active = 1'b0;

    packet_crc32_check_core dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .crc_value      (crc_value),
        .checksum_match (checksum_match)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Reflected CRC-32, one byte folded LSB first.
    function automatic logic [pcrc_pkg::CRC_W-1:0] crc_fold(
        input logic [pcrc_pkg::CRC_W-1:0] crc,
        input logic [7:0] b);
        logic [pcrc_pkg::CRC_W-1:0] r;
        r = crc ^ {{(pcrc_pkg::CRC_W-8){1'b0}}, b};
        for (int k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ pcrc_pkg::CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic bit in_sum_window(input int unsigned pos, input int unsigned off);
        return (pos >= off) && (pos < off + 4);
    endfunction

    task automatic report_mismatch(input string what, input logic [pcrc_pkg::CRC_W-1:0] got,
                                   input logic [pcrc_pkg::CRC_W-1:0] want);
        mismatch_count++;
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Result check first, then prediction: a result never belongs to the beat
    // accepted at the same edge, so this order keeps the queue honest.
    always @(posedge clk)
    begin
        crc_result_t want;
        logic [7:0]  feed;
        int unsigned lane;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_crc_q.size() == 0)
                    report_mismatch("result beat with none expected", crc_value, '0);
                else
                begin
                    want = pending_crc_q.pop_front();
                    if (crc_value !== want.crc)
                        report_mismatch("crc_value", crc_value, want.crc);
                    if (checksum_match !== want.match)
                        report_mismatch("checksum_match",
                                        pcrc_pkg::CRC_W'(checksum_match),
                                        pcrc_pkg::CRC_W'(want.match));
                end
            end
            if (in_valid && !in_stall)
            begin
                feed = data_byte;
                // checksum bytes are captured little-endian and folded as zero
                if (in_sum_window(byte_pos, sum_offset))
                begin
                    lane = byte_pos - sum_offset;
                    captured_sum[8*lane +: 8] = data_byte;
                    feed = 8'h00;
                end
                crc_acc = crc_fold(crc_acc, feed);
                if (byte_pos < pcrc_pkg::POS_TOP)
                    byte_pos++;
                if (last_byte)
                begin
                    want.crc   = ~crc_acc;
                    want.match = (~crc_acc == captured_sum);
                    pending_crc_q.push_back(want);
                    crc_acc      = pcrc_pkg::CRC_PRESET;
                    byte_pos     = '0;
                    captured_sum = '0;
                end
            end
        end
    end

    // Receiver: random stall stretches, or one long hold-off on request.
    initial
    begin
        int unsigned span;
        bit          stall_now;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_active = 1'b0;
            end
            else
            begin
                stall_now = ($urandom_range(99) < stall_pct);
                out_stall <= stall_now;
                if (stall_now)
                    span = ($urandom_range(9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
                else
                    span = $urandom_range(1, 8);
                repeat (span - 1) @(negedge clk);
            end
        end
    end

    // Offer one beat, with an optional idle gap first, and hold it until taken.
    task automatic send_beat(input logic [7:0] b, input logic last_flag);
        int unsigned gap;
        gap = 0;
        if ($urandom_range(99) < gap_pct)
            gap = ($urandom_range(7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 2);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid  <= 1'b0;
            data_byte <= 8'($urandom);   // idle payload is junk on purpose
            last_byte <= 1'($urandom);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last_flag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_buffer;
        foreach (pkt_buf[i])
            send_beat(pkt_buf[i], i == pkt_buf.size() - 1);
    endtask

    // Write the packet's own CRC into its checksum field (as much as fits).
    task automatic seal_checksum;
        logic [pcrc_pkg::CRC_W-1:0] crc;
        crc = pcrc_pkg::CRC_PRESET;
        foreach (pkt_buf[i])
            crc = crc_fold(crc, in_sum_window(i, sum_offset) ? 8'h00 : pkt_buf[i]);
        crc = ~crc;
        for (int k = 0; k < 4; k++)
            if (sum_offset + k < pkt_buf.size())
                pkt_buf[sum_offset + k] = crc[8*k +: 8];
    endtask

    task automatic send_packet(input int unsigned len, input pkt_kind_t kind);
        int unsigned idx;
        int unsigned bit_sel;
        pkt_buf.delete();
        repeat (len)
            pkt_buf.push_back(8'($urandom));
        if (kind != PKT_RANDOM)
            seal_checksum();
        if (kind == PKT_CORRUPT)
        begin
            idx     = $urandom_range(len - 1);
            bit_sel = $urandom_range(7);
            pkt_buf[idx][bit_sel] = ~pkt_buf[idx][bit_sel];
        end
        send_buffer();
    endtask

    // Drop valid and let every outstanding result come out.
    task automatic wait_idle;
        @(negedge clk);
        in_valid  <= 1'b0;
        last_byte <= 1'b0;
        while (pending_crc_q.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_offset(input logic [pcrc_pkg::OFFSET_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= value;
        sum_offset = value;
        @(negedge clk);
        cfg_we     <= 1'b0;
    endtask

    // Single-byte packets, a sealed packet at the reset offset, packets that
    // end inside and before the checksum field, and a packet that is all field.
    task automatic test_directed_edges;
        gap_pct   = 0;
        stall_pct = 0;
        send_beat(8'h00, 1'b1);
        pkt_buf = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA,
                    8'h00, 8'h00, 8'h00, 8'h00};
        seal_checksum();
        send_buffer();
        send_packet(9, PKT_RANDOM);
        send_packet(2, PKT_RANDOM);
        set_offset('0);
        send_packet(4, PKT_GOOD);
        send_beat(8'hFF, 1'b1);
    endtask

    // Offset near its top with a packet that never reaches the field, then a
    // long packet with its field deep inside.
    task automatic test_long_packets;
        gap_pct   = 5;
        stall_pct = 30;
        set_offset(11'd2044);
        send_packet(24, PKT_RANDOM);
        set_offset(11'd700);
        send_packet(708, PKT_GOOD);
    endtask

    // Receiver holds off for a long stretch while short packets keep coming.
    task automatic test_output_hold;
        set_offset(11'd3);
        gap_pct  = 0;
        hold_req = 1'b1;
        while (!hold_active)
            @(negedge clk);
        hold_req = 1'b0;
        repeat (24)
            send_packet($urandom_range(1, 7), PKT_GOOD);
    endtask

    // Mostly sealed packets with random content, plus corrupt and raw ones.
    task automatic test_random_packets;
        int unsigned sent;
        int unsigned phase_sent;
        int unsigned len;
        int unsigned off;
        int unsigned pick;
        pkt_kind_t   kind;
        sent = 0;
        for (int phase = 0; sent < RANDOM_BEATS; phase++)
        begin
            case (phase % 4)
                0:       off = 0;
                1:       off = $urandom_range(1, 16);
                2:       off = $urandom_range(17, 64);
                default: off = pcrc_pkg::OFFSET_RESET;
            endcase
            set_offset(pcrc_pkg::OFFSET_W'(off));
            gap_pct   = (phase % 3 == 0) ? 0 : $urandom_range(10, 50);
            stall_pct = (phase % 5 == 1) ? 0 : $urandom_range(10, 60);
            phase_sent = 0;
            while (phase_sent < PHASE_BEATS)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    kind = PKT_GOOD;
                else if (pick < 85)
                    kind = PKT_CORRUPT;
                else
                    kind = PKT_RANDOM;
                if (kind == PKT_RANDOM)
                    len = $urandom_range(1, off + 8);
                else
                    len = off + 4 + (($urandom_range(9) == 0) ? $urandom_range(13, 60)
                                                              : $urandom_range(0, 12));
                send_packet(len, kind);
                phase_sent += len;
            end
            sent += phase_sent;
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = pcrc_pkg::OFFSET_RESET;
        in_valid  = 1'b0;
        data_byte = 8'h00;
        last_byte = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_edges();
        test_long_packets();
        test_output_hold();
        test_random_packets();

        wait_idle();
        repeat (8) @(posedge clk);
        foreach (pending_crc_q[i])
            report_mismatch("result never arrived", '0, pending_crc_q[i].crc);
        if (mismatch_count == 0)
            $display("packet_crc32_check_core verification clean");
        else
            $display("packet_crc32_check_core verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("packet_crc32_check_core verification failed");
        $finish;
    end

endmodule
